### src/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// shared types and constants of the free-list index allocator
// ----------------------------------------------------------------------------
package fla_pkg;

    // pool geometry
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_e;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status_e;

    // sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state_e;

endpackage : fla_pkg

### src/free_list_index_allocator_core.sv
// ----------------------------------------------------------------------------
// free_list_index_allocator_core
// Slot index allocator over a fixed pool of 1024 slots. A request is taken
// when start is high and busy is low; every request gives exactly one result
// transfer, shown for one cycle on o_result_index / o_status with o_valid
// high, and the receiver cannot stall it. Each request runs as follows:
// the accept edge launches the reads of the free stack top and of the live
// mark, the following cycle decides and writes both memories back, and the
// result appears in the cycle after that, when busy has already dropped so
// the next request can be taken alongside the result. This sequence follows
// from the registered reads of the free stack and live-mark memories
// followed by their write-back. Allocate pops the most recently
// freed index or else takes the next fresh one from the high-water cursor
// (status full when neither is left, index 0); free accepts only a live
// index below the cursor (otherwise status invalid); query reports ok for a
// live index; clear empties the pool with status ok and index 0. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module free_list_index_allocator_core
    import fla_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_req_type,
    input  logic [IDX_W-1:0] i_slot_index,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_result_index,
    output logic [1:0]       o_status
);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state_e         r_state, n_state;
    logic [CNT_W-1:0] r_stack_count, n_stack_count;
    logic [CNT_W-1:0] r_high_water, n_high_water;

    // request held across the execute cycle
    logic [1:0]       r_req;
    logic [IDX_W-1:0] r_idx;

    // memories: free stack and per-slot live marks
    logic [IDX_W-1:0] r_stack_mem [CAPACITY];
    logic             r_live_mem  [CAPACITY];
    logic [IDX_W-1:0] r_stack_q;
    logic             r_live_q;

    // result register
    logic             r_valid;
    logic [IDX_W-1:0] r_result_index, n_result_index;
    logic [1:0]       r_status, n_status;

    // write-back controls
    logic             stack_we;
    logic [IDX_W-1:0] stack_waddr;
    logic             live_we;
    logic [IDX_W-1:0] live_waddr;
    logic             live_wdata;

    logic             accept;
    logic [IDX_W-1:0] stack_raddr;
    logic             below_hw;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    // top of stack: only meaningful when the count is non-zero
    assign stack_raddr = IDX_W'(r_stack_count - CNT_W'(1));

    // ------------------------------------------------------------------
    // memory reads, launched at the accept edge
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stack_q <= r_stack_mem[stack_raddr];
            r_live_q  <= r_live_mem[i_slot_index];
            r_req     <= i_req_type;
            r_idx     <= i_slot_index;
        end
    end

    // memory write-back in the execute cycle
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack_mem[stack_waddr] <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            r_live_mem[live_waddr] <= live_wdata;
        end
    end

    // ------------------------------------------------------------------
    // execute: decide from the read data, update cursor and count
    // ------------------------------------------------------------------
    assign below_hw = ({1'b0, r_idx} < r_high_water);

    always_comb begin
        n_state        = r_state;
        n_stack_count  = r_stack_count;
        n_high_water   = r_high_water;
        n_result_index = r_result_index;
        n_status       = r_status;
        stack_we       = 1'b0;
        stack_waddr    = r_stack_count[IDX_W-1:0];
        live_we        = 1'b0;
        live_waddr     = r_idx;
        live_wdata     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state        = S_IDLE;
                n_result_index = r_idx;
                n_status       = ST_OK;
                unique case (r_req)
                    REQ_ALLOC: begin
                        if (r_stack_count != '0) begin
                            // reuse the most recently freed slot
                            n_stack_count  = r_stack_count - CNT_W'(1);
                            n_result_index = r_stack_q;
                            live_we        = 1'b1;
                            live_waddr     = r_stack_q;
                            live_wdata     = 1'b1;
                        end else if (r_high_water < CNT_W'(CAPACITY)) begin
                            // fresh slot from the cursor
                            n_high_water   = r_high_water + CNT_W'(1);
                            n_result_index = r_high_water[IDX_W-1:0];
                            live_we        = 1'b1;
                            live_waddr     = r_high_water[IDX_W-1:0];
                            live_wdata     = 1'b1;
                        end else begin
                            n_result_index = '0;
                            n_status       = ST_FULL;
                        end
                    end
                    REQ_FREE: begin
                        if (below_hw && r_live_q &&
                            (r_stack_count < CNT_W'(CAPACITY))) begin
                            live_we       = 1'b1;
                            live_wdata    = 1'b0;
                            stack_we      = 1'b1;
                            n_stack_count = r_stack_count + CNT_W'(1);
                        end else begin
                            n_status = ST_INVALID;
                        end
                    end
                    REQ_QUERY: begin
                        if (!(below_hw && r_live_q)) begin
                            n_status = ST_INVALID;
                        end
                    end
                    REQ_CLEAR: begin
                        // live marks are left alone: they are only read below the cursor
                        n_high_water   = '0;
                        n_stack_count  = '0;
                        n_result_index = '0;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_stack_count <= '0;
            r_high_water  <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_stack_count <= n_stack_count;
            r_high_water  <= n_high_water;
            r_valid       <= (r_state == S_EXEC);
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_result_index <= n_result_index;
        r_status       <= n_status;
    end

    assign o_valid        = r_valid;
    assign o_result_index = r_result_index;
    assign o_status       = r_status;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted request always leads to the execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    // every execute cycle gives exactly one result transfer right after it
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("execute cycle did not produce a result");

    // a full status only when the cursor has reached capacity and the stack is empty
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |->
            ((r_high_water == CNT_W'(CAPACITY)) && (r_stack_count == '0)
             && (o_result_index == '0)))
        else $error("full status reported with slots left");

    // stack can never hold more entries than slots handed out
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stack_count <= r_high_water))
        else $error("free stack deeper than high-water cursor");

endmodule : free_list_index_allocator_core
